// File: hdl/psm_pkg.sv
// Shared types and constants for the PS/2 mouse device-side block.
`default_nettype none
package psm_pkg;

  // Depth of the response queue between decode and serializer.
  localparam int QueueDepthDefault = 2;
  localparam int MaxBytes          = 5;

  // Item command codes.
  localparam logic [2:0] CmdHost    = 3'd0;
  localparam logic [2:0] CmdPress   = 3'd1;
  localparam logic [2:0] CmdRelease = 3'd2;
  localparam logic [2:0] CmdScroll  = 3'd3;
  localparam logic [2:0] CmdMove    = 3'd4;
  localparam logic [2:0] CmdPlace   = 3'd5;

  // Host command bytes.
  localparam logic [7:0] HostReset      = 8'hFF;
  localparam logic [7:0] HostResend     = 8'hFE;
  localparam logic [7:0] HostDefaults   = 8'hF6;
  localparam logic [7:0] HostDisable    = 8'hF5;
  localparam logic [7:0] HostEnable     = 8'hF4;
  localparam logic [7:0] HostSetRate    = 8'hF3;
  localparam logic [7:0] HostGetId      = 8'hF2;
  localparam logic [7:0] HostRemote     = 8'hF0;
  localparam logic [7:0] HostWrap       = 8'hEE;
  localparam logic [7:0] HostWrapReset  = 8'hEC;
  localparam logic [7:0] HostReadData   = 8'hEB;
  localparam logic [7:0] HostStream     = 8'hEA;
  localparam logic [7:0] HostStatus     = 8'hE9;
  localparam logic [7:0] HostSetRes     = 8'hE8;
  localparam logic [7:0] HostScale21    = 8'hE7;
  localparam logic [7:0] HostScale11    = 8'hE6;

  // Response bytes.
  localparam logic [7:0] RspAck   = 8'hFA;
  localparam logic [7:0] RspNak   = 8'hFE;
  localparam logic [7:0] BatPass  = 8'hAA;
  localparam logic [7:0] IdWheel  = 8'h03;
  localparam logic [7:0] IdPlain  = 8'h00;

  // Wheel unlock rate sequence.
  localparam logic [7:0] WheelRate1 = 8'd200;
  localparam logic [7:0] WheelRate2 = 8'd100;
  localparam logic [7:0] WheelRate3 = 8'd80;
  localparam logic [1:0] WheelOn    = 2'd3;

  localparam logic [7:0] ResDefault = 8'd2;

  // Bytes caused by one item; bytes[0] goes out first.
  typedef struct packed {
    logic [2:0]      n;
    logic [4:0][7:0] bytes;
  } rsp_t;

endpackage
`default_nettype wire

// File: hdl/ps2_mouse_device_side.sv
// Top level of the PS/2 mouse device side: decode, response queue, serializer.
//
// Input channel: in_valid_i / in_stall_o with fields command_i, host_byte_i,
//   button_mask_i, move_x_i, move_y_i, scroll_step_i. A transaction takes
//   place on a clock edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i carrying out_byte_o and last_o;
//   last_o marks the final byte caused by one input item. Items that cause
//   no bytes produce no output transaction.
// Throughput: one input item per cycle while the response queue has room;
//   the serializer sends one byte per cycle while out_stall_i is low, so an
//   item producing n bytes (1 to 5) holds the output side until all n
//   are sent. Sustained rate is set by the serializer's byte count.
// Path: an accepted item is written into the response queue, and its first
//   byte is then loaded from the queue head into the output register.
// Reset (rst_ni low, async): command state, stream mode, reporting off,
//   resolution 2, everything else zero; queue and output register empty.
// Output stall: the output byte holds; the queue fills and then in_stall_o
//   rises, which holds off new items.
`default_nettype none
module ps2_mouse_device_side #(
  parameter int QueueDepth = psm_pkg::QueueDepthDefault
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [2:0]        command_i,
  input  wire  [7:0]        host_byte_i,
  input  wire  [2:0]        button_mask_i,
  input  wire  signed [15:0] move_x_i,
  input  wire  signed [15:0] move_y_i,
  input  wire  signed [7:0] scroll_step_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              last_o
);
  import psm_pkg::*;

  // decode -> queue
  logic push;
  rsp_t push_rec;
  logic full;
  // queue -> serializer
  logic head_valid;
  rsp_t head_rec;
  logic pop;

  psm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .host_byte_i   (host_byte_i),
    .button_mask_i (button_mask_i),
    .move_x_i      (move_x_i),
    .move_y_i      (move_y_i),
    .scroll_step_i (scroll_step_i),
    .full_i        (full),
    .push_o        (push),
    .rsp_o         (push_rec)
  );

  psm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_rec),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_rec)
  );

  psm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_rec),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

// File: hdl/psm_front.sv
// Decode and state update: turns each item into a response record.
`default_nettype none
module psm_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire  [2:0]        command_i,
  input  wire  [7:0]        host_byte_i,
  input  wire  [2:0]        button_mask_i,
  input  wire  signed [15:0] move_x_i,
  input  wire  signed [15:0] move_y_i,
  input  wire  signed [7:0] scroll_step_i,
  input  wire               full_i,
  output logic              push_o,
  output psm_pkg::rsp_t     rsp_o
);
  import psm_pkg::*;

  typedef enum logic [1:0] {
    ProtoCmd  = 2'd0,
    ProtoRate = 2'd1,
    ProtoWrap = 2'd2,
    ProtoRes  = 2'd3
  } proto_e;

  proto_e      proto_q, proto_d;
  logic        remote_q, remote_d;
  logic        report_q, report_d;
  logic [7:0]  res_q, res_d;
  logic [7:0]  rate_q, rate_d;
  logic [1:0]  wheel_q, wheel_d;
  logic [2:0]  btn_q, btn_d;
  logic [9:0]  cnt_x_q, cnt_x_d;
  logic [9:0]  cnt_y_q, cnt_y_d;
  logic        ovf_x_q, ovf_x_d;
  logic        ovf_y_q, ovf_y_d;
  logic [7:0]  scroll_q, scroll_d;
  logic [31:0] pos_x_q, pos_x_d;
  logic [31:0] pos_y_q, pos_y_d;

  logic        accept;
  logic        streaming;
  logic        exec_cmd;
  logic        send_pkt;
  logic        ack_first;
  logic [31:0] dx, dy;
  logic [13:0] sx, sy;       // {too_big, low 13 bits}
  logic [12:0] vx, vy;
  logic [10:0] nx, ny;       // {overflow, counter}
  logic [3:0][7:0] pkt;
  logic [2:0]  plen;
  logic [7:0]  status;
  rsp_t        rsp;

  // Scale a delta by the resolution code. Returns {doesn't fit 12 bits, low 13 bits}.
  function automatic logic [13:0] scale13(input logic [31:0] d, input logic [7:0] r);
    logic signed [47:0] w;
    logic [4:0]         sh;
    logic               big;
    w = {{16{d[31]}}, d};
    if (r <= 8'd3) begin
      w = w >>> (~r[1:0]);
    end else begin
      if (r >= 8'd19) sh = 5'd16;
      else            sh = 5'(r - 8'd3);
      w = w <<< sh;
    end
    big = !((&w[47:11]) || !(|w[47:11]));
    return {big, w[12:0]};
  endfunction

  // Range check of a new counter value; out of range keeps low 8 bits sign extended.
  function automatic logic [10:0] clamp(input logic [12:0] v, input logic big);
    logic ovf;
    ovf = big || (!v[12] && (|v[11:8])) || (v[12] && !(&v[11:9]));
    if (ovf) return {1'b1, {2{v[7]}}, v[7:0]};
    return {1'b0, v[9:0]};
  endfunction

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign streaming  = !remote_q && report_q;
  assign exec_cmd   = (proto_q == ProtoCmd) ||
                      ((proto_q == ProtoWrap) &&
                       (host_byte_i == HostWrapReset || host_byte_i == HostReset));
  assign status     = {1'b0, remote_q, report_q, 2'b00, btn_q[0], btn_q[2], btn_q[1]};

  // Movement datapath, evaluated every cycle and used for move and place.
  always_comb begin
    dx = {{16{move_x_i[15]}}, move_x_i};
    dy = {{16{move_y_i[15]}}, move_y_i};
    if (command_i == CmdPlace) begin
      dx = dx - pos_x_q;
      dy = dy - pos_y_q;
    end
    sx = scale13(dx, res_q);
    sy = scale13(dy, res_q);
    vx = {{3{cnt_x_q[9]}}, cnt_x_q} + sx[12:0];
    vy = {{3{cnt_y_q[9]}}, cnt_y_q} - sy[12:0];
    nx = clamp(vx, sx[13]);
    ny = clamp(vy, sy[13]);
  end

  always_comb begin
    proto_d  = proto_q;
    remote_d = remote_q;
    report_d = report_q;
    res_d    = res_q;
    rate_d   = rate_q;
    wheel_d  = wheel_q;
    btn_d    = btn_q;
    cnt_x_d  = cnt_x_q;
    cnt_y_d  = cnt_y_q;
    ovf_x_d  = ovf_x_q;
    ovf_y_d  = ovf_y_q;
    scroll_d = scroll_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    send_pkt  = 1'b0;
    ack_first = 1'b0;
    rsp       = '0;
    pkt       = '0;
    plen      = 3'd3;

    case (command_i)
      CmdHost: begin
        if (exec_cmd) begin
          case (host_byte_i)
            HostReset: begin
              remote_d = 1'b0; proto_d = ProtoCmd; report_d = 1'b0; res_d = ResDefault;
              rsp.bytes[0] = RspAck; rsp.bytes[1] = BatPass; rsp.bytes[2] = 8'h00;
              rsp.n = 3'd3;
            end
            HostResend: ;
            HostDefaults: begin
              remote_d = 1'b0; proto_d = ProtoCmd; report_d = 1'b0; res_d = ResDefault;
              rsp.bytes[0] = RspAck; rsp.n = 3'd1;
            end
            HostDisable: begin
              report_d = 1'b0; rsp.bytes[0] = RspAck; rsp.n = 3'd1;
            end
            HostEnable: begin
              report_d = 1'b1; rsp.bytes[0] = RspAck; rsp.n = 3'd1;
            end
            HostSetRate: begin
              proto_d = ProtoRate; rsp.bytes[0] = RspAck; rsp.n = 3'd1;
            end
            HostGetId: begin
              rsp.bytes[0] = RspAck;
              rsp.bytes[1] = (wheel_q == WheelOn) ? IdWheel : IdPlain;
              rsp.n = 3'd2;
            end
            HostRemote, HostStream, HostWrap, HostWrapReset: begin
              cnt_x_d = '0; cnt_y_d = '0; ovf_x_d = 1'b0; ovf_y_d = 1'b0; scroll_d = '0;
              if (host_byte_i == HostRemote)    remote_d = 1'b1;
              if (host_byte_i == HostStream)    remote_d = 1'b0;
              if (host_byte_i == HostWrap)      proto_d  = ProtoWrap;
              if (host_byte_i == HostWrapReset) proto_d  = ProtoCmd;
              rsp.bytes[0] = RspAck; rsp.n = 3'd1;
            end
            HostReadData: begin
              send_pkt = 1'b1; ack_first = 1'b1;
            end
            HostStatus: begin
              rsp.bytes[0] = RspAck; rsp.bytes[1] = status;
              rsp.bytes[2] = res_q;  rsp.bytes[3] = rate_q;
              rsp.n = 3'd4;
            end
            HostSetRes: begin
              proto_d = ProtoRes; rsp.bytes[0] = RspAck; rsp.n = 3'd1;
            end
            HostScale21, HostScale11: begin
              rsp.bytes[0] = RspAck; rsp.n = 3'd1;
            end
            default: begin
              rsp.bytes[0] = RspNak; rsp.n = 3'd1;
            end
          endcase
        end else begin
          case (proto_q)
            ProtoRate: begin
              rate_d = host_byte_i;
              if (wheel_q == 2'd0 && host_byte_i == WheelRate1)      wheel_d = 2'd1;
              else if (wheel_q == 2'd1 && host_byte_i == WheelRate2) wheel_d = 2'd2;
              else if (wheel_q == 2'd2 && host_byte_i == WheelRate3) wheel_d = WheelOn;
              else if (wheel_q != WheelOn)                           wheel_d = 2'd0;
              proto_d = ProtoCmd;
              rsp.bytes[0] = RspAck; rsp.n = 3'd1;
            end
            ProtoRes: begin
              res_d = host_byte_i; proto_d = ProtoCmd;
              rsp.bytes[0] = RspAck; rsp.n = 3'd1;
            end
            default: begin
              // wrap mode echo
              rsp.bytes[0] = host_byte_i; rsp.n = 3'd1;
            end
          endcase
        end
      end
      CmdPress: begin
        btn_d    = btn_q | button_mask_i;
        send_pkt = (btn_d != btn_q) && streaming;
      end
      CmdRelease: begin
        btn_d    = btn_q & ~button_mask_i;
        send_pkt = (btn_d != btn_q) && streaming;
      end
      CmdScroll: begin
        scroll_d = scroll_q + scroll_step_i;
        send_pkt = streaming;
      end
      CmdMove, CmdPlace: begin
        pos_x_d  = pos_x_q + dx;
        pos_y_d  = pos_y_q + dy;
        cnt_x_d  = nx[9:0];
        cnt_y_d  = ny[9:0];
        ovf_x_d  = ovf_x_q | nx[10];
        ovf_y_d  = ovf_y_q | ny[10];
        send_pkt = streaming;
      end
      default: ;
    endcase

    if (send_pkt) begin
      pkt[0] = {ovf_y_d, ovf_x_d, cnt_y_d[9], cnt_x_d[9], 1'b1, btn_d};
      pkt[1] = cnt_x_d[7:0];
      pkt[2] = cnt_y_d[7:0];
      pkt[3] = scroll_d;
      plen   = (wheel_q == WheelOn) ? 3'd4 : 3'd3;
      if (ack_first) begin
        rsp.bytes = {pkt, RspAck};
        rsp.n     = plen + 3'd1;
      end else begin
        rsp.bytes = {8'h00, pkt};
        rsp.n     = plen;
      end
      cnt_x_d = '0; cnt_y_d = '0; ovf_x_d = 1'b0; ovf_y_d = 1'b0; scroll_d = '0;
    end
  end

  assign push_o = accept && (rsp.n != 3'd0);
  assign rsp_o  = rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_q  <= ProtoCmd;
      remote_q <= 1'b0;
      report_q <= 1'b0;
      res_q    <= ResDefault;
      rate_q   <= '0;
      wheel_q  <= '0;
      btn_q    <= '0;
      cnt_x_q  <= '0;
      cnt_y_q  <= '0;
      ovf_x_q  <= 1'b0;
      ovf_y_q  <= 1'b0;
      scroll_q <= '0;
      pos_x_q  <= '0;
      pos_y_q  <= '0;
    end else if (accept) begin
      proto_q  <= proto_d;
      remote_q <= remote_d;
      report_q <= report_d;
      res_q    <= res_d;
      rate_q   <= rate_d;
      wheel_q  <= wheel_d;
      btn_q    <= btn_d;
      cnt_x_q  <= cnt_x_d;
      cnt_y_q  <= cnt_y_d;
      ovf_x_q  <= ovf_x_d;
      ovf_y_q  <= ovf_y_d;
      scroll_q <= scroll_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
    end
  end

  // counters stay within -512..255
  a_cnt_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x_q[9:8] != 2'b01) else $error("count_x out of range");
  a_cnt_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_y_q[9:8] != 2'b01) else $error("count_y out of range");
  a_push_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (rsp_o.n <= 3'(MaxBytes)) && !full_i) else $error("bad push");

endmodule
`default_nettype wire

// File: hdl/psm_queue.sv
// Small FIFO of response records between decode and serializer.
`default_nettype none
module psm_queue #(
  parameter int Depth = psm_pkg::QueueDepthDefault
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  input  psm_pkg::rsp_t push_data_i,
  output logic          full_o,
  input  wire           pop_i,
  output logic          head_valid_o,
  output psm_pkg::rsp_t head_o
);
  import psm_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  rsp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i)      count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("pop from empty queue");
  a_no_empty_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> push_data_i.n != 3'd0) else $error("empty record queued");

endmodule
`default_nettype wire

// File: hdl/psm_back.sv
// Serializer: sends the bytes of each queued record through an output register.
`default_nettype none
module psm_back (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           head_valid_i,
  input  psm_pkg::rsp_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire           out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          last_o
);
  import psm_pkg::*;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       last_q;
  logic [2:0] idx_q;
  logic       load;
  logic       take;
  logic       is_last;

  assign load    = !out_valid_q || !out_stall_i;
  assign take    = load && head_valid_i;
  assign is_last = (idx_q == head_i.n - 3'd1);
  assign pop_o   = take && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) out_valid_q <= head_valid_i;
      if (take) idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_byte_q <= head_i.bytes[idx_q];
      last_q     <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_o      = last_q;

  a_idx_in_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q < head_i.n) else $error("byte index past record");
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> idx_q == 3'd0) else $error("index not cleared");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_o && last_o) else $error("pop without last byte");

endmodule
`default_nettype wire

// File: tb/psm_reply_checker.sv
// Watches both channels of the PS/2 mouse block, predicts its reply bytes and compares them.
`timescale 1ns / 100ps
module psm_reply_checker
  import psm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [2:0]         command_i,
  input  logic [7:0]         host_byte_i,
  input  logic [2:0]         button_mask_i,
  input  logic signed [15:0] move_x_i,
  input  logic signed [15:0] move_y_i,
  input  logic signed [7:0]  scroll_step_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [7:0]         out_byte_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef enum logic [1:0] {PsCmd, PsRate, PsWrap, PsRes} proto_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } reply_byte_t;

  // Mirror of the mouse state.
  proto_e      proto;
  logic        remote;
  logic        reporting;
  logic [7:0]  resolution;
  logic [7:0]  sample_rate;
  logic [1:0]  wheel_stage;
  logic [2:0]  buttons;
  logic [9:0]  count_x, count_y;
  logic        ovf_x, ovf_y;
  logic [7:0]  scroll_acc;
  logic [31:0] pos_x, pos_y;

  logic [7:0]  staged[$];
  reply_byte_t awaited_bytes[$];
  int          k;

  initial fail_count_o = 0;
  initial pending_o = 0;

  task report_mismatch(input string what);
    fail_count_o++;
    $display("MISMATCH @%0t: %s", $time, what);
  endtask

  task clear_counts();
    count_x = '0;
    count_y = '0;
    ovf_x = 1'b0;
    ovf_y = 1'b0;
    scroll_acc = '0;
  endtask

  task load_defaults();
    remote = 1'b0;
    proto = PsCmd;
    reporting = 1'b0;
    resolution = ResDefault;
  endtask

  task power_on();
    load_defaults();
    sample_rate = '0;
    wheel_stage = '0;
    buttons = '0;
    clear_counts();
    pos_x = '0;
    pos_y = '0;
  endtask

  function automatic logic streaming();
    return !remote && reporting;
  endfunction

  // Codes 0..3 divide (floor), larger codes multiply, capped at a shift of 16.
  function automatic longint rescale(longint d);
    int s;
    if (resolution <= 8'd3) begin
      s = 3 - int'(resolution);
      return d >>> s;
    end
    s = int'(resolution) - 3;
    if (s > 16) s = 16;
    return d <<< s;
  endfunction

  // Bit 10 flags an overflow; the kept value is the low byte sign extended.
  function automatic logic [10:0] fold_count(longint v);
    if (v > 255 || v < -512) return {1'b1, {2{v[7]}}, v[7:0]};
    return {1'b0, v[9:0]};
  endfunction

  task queue_packet();
    staged.push_back({ovf_y, ovf_x, count_y[9], count_x[9], 1'b1, buttons});
    staged.push_back(count_x[7:0]);
    staged.push_back(count_y[7:0]);
    if (wheel_stage == WheelOn) staged.push_back(scroll_acc);
    clear_counts();
  endtask

  task apply_move(input longint dx, input longint dy);
    longint nx, ny;
    logic [10:0] fx, fy;
    pos_x = pos_x + dx[31:0];
    pos_y = pos_y + dy[31:0];
    nx = rescale(dx) + longint'($signed(count_x));
    ny = longint'($signed(count_y)) - rescale(dy);
    fx = fold_count(nx);
    fy = fold_count(ny);
    ovf_x = ovf_x | fx[10];
    ovf_y = ovf_y | fy[10];
    count_x = fx[9:0];
    count_y = fy[9:0];
    if (streaming()) queue_packet();
  endtask

  task run_command(input logic [7:0] b);
    case (b)
      HostReset: begin
        load_defaults();
        staged.push_back(RspAck);
        staged.push_back(BatPass);
        staged.push_back(IdPlain);
      end
      HostResend: ;
      HostDefaults: begin
        load_defaults();
        staged.push_back(RspAck);
      end
      HostDisable: begin
        reporting = 1'b0;
        staged.push_back(RspAck);
      end
      HostEnable: begin
        reporting = 1'b1;
        staged.push_back(RspAck);
      end
      HostSetRate: begin
        proto = PsRate;
        staged.push_back(RspAck);
      end
      HostGetId: begin
        staged.push_back(RspAck);
        staged.push_back(wheel_stage == WheelOn ? IdWheel : IdPlain);
      end
      HostRemote: begin
        clear_counts();
        remote = 1'b1;
        staged.push_back(RspAck);
      end
      HostWrap: begin
        clear_counts();
        proto = PsWrap;
        staged.push_back(RspAck);
      end
      HostWrapReset: begin
        clear_counts();
        proto = PsCmd;
        staged.push_back(RspAck);
      end
      HostReadData: begin
        staged.push_back(RspAck);
        queue_packet();
      end
      HostStream: begin
        clear_counts();
        remote = 1'b0;
        staged.push_back(RspAck);
      end
      HostStatus: begin
        staged.push_back(RspAck);
        // right, middle, left in bits 0..2; reporting bit 5, remote bit 6
        staged.push_back({1'b0, remote, reporting, 2'b00, buttons[0], buttons[2], buttons[1]});
        staged.push_back(resolution);
        staged.push_back(sample_rate);
      end
      HostSetRes: begin
        proto = PsRes;
        staged.push_back(RspAck);
      end
      HostScale21, HostScale11: staged.push_back(RspAck);
      default: staged.push_back(RspNak);
    endcase
  endtask

  task take_host_byte(input logic [7:0] b);
    case (proto)
      PsCmd: run_command(b);
      PsRate: begin
        sample_rate = b;
        if (wheel_stage == 2'd0 && b == WheelRate1) wheel_stage = 2'd1;
        else if (wheel_stage == 2'd1 && b == WheelRate2) wheel_stage = 2'd2;
        else if (wheel_stage == 2'd2 && b == WheelRate3) wheel_stage = WheelOn;
        else if (wheel_stage != WheelOn) wheel_stage = 2'd0;
        proto = PsCmd;
        staged.push_back(RspAck);
      end
      PsWrap: begin
        if (b == HostWrapReset || b == HostReset) run_command(b);
        else staged.push_back(b);
      end
      default: begin
        resolution = b;
        proto = PsCmd;
        staged.push_back(RspAck);
      end
    endcase
  endtask

  task predict_replies();
    logic [2:0]  prev;
    logic [31:0] gap_x, gap_y;
    reply_byte_t rb;
    staged.delete();
    case (command_i)
      CmdHost: take_host_byte(host_byte_i);
      CmdPress: begin
        prev = buttons;
        buttons = buttons | button_mask_i;
        if (buttons != prev && streaming()) queue_packet();
      end
      CmdRelease: begin
        prev = buttons;
        buttons = buttons & ~button_mask_i;
        if (buttons != prev && streaming()) queue_packet();
      end
      CmdScroll: begin
        scroll_acc = scroll_acc + scroll_step_i;
        if (streaming()) queue_packet();
      end
      CmdMove: apply_move(longint'(move_x_i), longint'(move_y_i));
      CmdPlace: begin
        gap_x = {{16{move_x_i[15]}}, move_x_i} - pos_x;
        gap_y = {{16{move_y_i[15]}}, move_y_i} - pos_y;
        apply_move(longint'($signed(gap_x)), longint'($signed(gap_y)));
      end
      default: ;
    endcase
    for (k = 0; k < staged.size(); k++) begin
      rb.data = staged[k];
      rb.is_last = (k == staged.size() - 1);
      awaited_bytes.push_back(rb);
    end
  endtask

  task check_byte();
    reply_byte_t want;
    if (awaited_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h last=%0b", out_byte_i, last_i));
    end else begin
      want = awaited_bytes.pop_front();
      if (out_byte_i !== want.data)
        report_mismatch($sformatf("byte %02h, want %02h", out_byte_i, want.data));
      if (last_i !== want.is_last)
        report_mismatch($sformatf("last=%0b on byte %02h, want %0b", last_i, out_byte_i,
                                  want.is_last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_on();
      awaited_bytes.delete();
      pending_o = 0;
    end else begin
      // output first: a byte never leaves in the cycle its item is taken
      if (out_valid_i && !out_stall_i) check_byte();
      if (in_valid_i && !in_stall_i) predict_replies();
      pending_o = awaited_bytes.size();
    end
  end

endmodule

// File: tb/tb.sv
// Top of the PS/2 mouse device-side testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb;
  import psm_pkg::*;

  // Command codes the block must ignore.
  localparam logic [2:0] CmdUnusedA = 3'd6;
  localparam logic [2:0] CmdUnusedB = 3'd7;
  // A host byte that no command decodes.
  localparam logic [7:0] HostBogus  = 8'h00;

  localparam int ItemTarget = 180;  // directed part plus random fill

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         command = '0;
  logic [7:0]         host_byte = '0;
  logic [2:0]         button_mask = '0;
  logic signed [15:0] move_x = '0;
  logic signed [15:0] move_y = '0;
  logic signed [7:0]  scroll_step = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_byte;
  logic               last;

  int fail_count;
  int pending;
  int items_sent = 0;
  int pick;

  // calm: no idling on either side; pressure_go: receiver holds off once
  logic calm = 1'b0;
  logic pressure_go = 1'b0;
  logic pressure_done = 1'b0;

  // Commands picked at random; enable is weighted up so packets keep flowing.
  logic [7:0] host_cmds [0:14] = '{HostEnable, HostEnable, HostEnable, HostReadData,
                                   HostStatus, HostGetId, HostDisable, HostDefaults,
                                   HostReset, HostRemote, HostStream, HostStream,
                                   HostScale21, HostScale11, HostResend};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ps2_mouse_device_side u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .command_i     (command),
    .host_byte_i   (host_byte),
    .button_mask_i (button_mask),
    .move_x_i      (move_x),
    .move_y_i      (move_y),
    .scroll_step_i (scroll_step),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte_o    (out_byte),
    .last_o        (last)
  );

  // The checker sits beside the block and sees exactly what the block sees.
  psm_reply_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .command_i     (command),
    .host_byte_i   (host_byte),
    .button_mask_i (button_mask),
    .move_x_i      (move_x),
    .move_y_i      (move_y),
    .scroll_step_i (scroll_step),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_byte_i    (out_byte),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Mostly small deltas so counters move without saturating every time;
  // now and then a full 16-bit value to toggle every bit.
  function automatic logic [15:0] rnd_move();
    if ($urandom_range(0, 3) != 0) return 16'($urandom_range(0, 80)) - 16'd40;
    return 16'($urandom);
  endfunction

  // Offer one item and hold it until the block takes the transaction.
  // Called at a rising edge; returns at the edge where the item was accepted,
  // with valid still high so back-to-back items need no extra assignment.
  task send_item(input logic [2:0] cmd, input logic [7:0] hb, input logic [2:0] mask,
                 input logic [15:0] mx, input logic [15:0] my, input logic [7:0] step);
    while (!calm && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    host_byte   <= hb;
    button_mask <= mask;
    move_x      <= mx;
    move_y      <= my;
    scroll_step <= step;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd != CmdUnusedA && cmd != CmdUnusedB) items_sent++;
    // a quiet stretch in the middle of the random part, then one long hold-off
    calm <= (items_sent >= 90 && items_sent < 130);
    if (items_sent == 150) pressure_go <= 1'b1;
  endtask

  // Host byte with every other field filled with noise.
  task send_host(input logic [7:0] b);
    send_item(CmdHost, b, 3'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // The rate sequence that unlocks the wheel (ID 3, 4-byte packets).
  task send_unlock();
    send_host(HostSetRate);
    send_host(WheelRate1);
    send_host(HostSetRate);
    send_host(WheelRate2);
    send_host(HostSetRate);
    send_host(WheelRate3);
  endtask

  // Receiver: random stalls, none while calm, and one long hold-off
  // while the sender keeps offering so the response queue backs up.
  initial begin
    forever begin
      @(posedge clk);
      if (pressure_go && !pressure_done) begin
        pressure_done = 1'b1;
        out_stall <= 1'b1;
        repeat (64) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 11);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    // Unused command with every field at an extreme: must be ignored.
    send_item(CmdUnusedA, 8'hFF, 3'b111, 16'h7FFF, 16'h8000, 8'h80);
    send_host(HostGetId);       // plain ID before the wheel is unlocked
    send_host(HostStatus);
    send_host(HostResend);      // resend is answered with silence
    send_host(HostBogus);       // unknown command gets a NAK
    send_host(HostEnable);
    // Press all buttons, then a maximal move that overflows both counters.
    send_item(CmdPress, 8'h00, 3'b111, 16'h0000, 16'h0000, 8'h00);
    send_item(CmdMove, 8'hFF, 3'b000, 16'h7FFF, 16'h8000, 8'h7F);
    send_item(CmdScroll, 8'h00, 3'b000, 16'hFFFF, 16'h0000, 8'h80);
    send_item(CmdRelease, 8'hFF, 3'b111, 16'h0000, 16'hFFFF, 8'hFF);
    send_unlock();
    send_host(HostGetId);       // now reports the wheel ID
    // Largest resolution: shift capped at 16, then a placement at the corners.
    send_host(HostSetRes);
    send_host(8'hFF);
    send_item(CmdPlace, 8'h00, 3'b000, 16'h8000, 16'h7FFF, 8'h01);
    // Wrap mode: echo, reset from inside wrap, and leaving wrap.
    send_host(HostWrap);
    send_host(8'h5A);
    send_host(HostReset);
    send_host(HostWrap);
    send_host(HostWrapReset);
    // Remote mode: events stay silent until the host polls.
    send_host(HostRemote);
    send_host(HostReadData);

    // Random part: well-formed command sequences with random content, plus noise.
    while (items_sent < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_unlock();
      end else if (pick < 10) begin
        send_host(HostSetRate);
        send_host(8'($urandom));
      end else if (pick < 16) begin
        send_host(HostSetRes);
        send_host(pick < 13 ? 8'($urandom_range(0, 3)) : 8'($urandom));
      end else if (pick < 20) begin
        send_host(HostWrap);
        repeat ($urandom_range(1, 3)) send_host(8'($urandom));
        send_host(HostWrapReset);
      end else if (pick < 38) begin
        send_host(host_cmds[$urandom_range(0, 14)]);
      end else if (pick < 41) begin
        send_host(8'($urandom));
      end else if (pick < 43) begin
        send_item(pick == 41 ? CmdUnusedA : CmdUnusedB, 8'($urandom), 3'($urandom),
                  16'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        send_item(CmdPress + 3'($urandom_range(0, 4)), 8'($urandom), 3'($urandom),
                  rnd_move(), rnd_move(), 8'($urandom));
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted byte, then a few more cycles for strays.
    // Sampled at the falling edge, clear of the checker's updates.
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (24) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: ps2_mouse_device_side.f
hdl/psm_pkg.sv
hdl/psm_front.sv
hdl/psm_queue.sv
hdl/psm_back.sv
hdl/ps2_mouse_device_side.sv
tb/psm_reply_checker.sv
tb/tb.sv
